// ===== hw/rtl/brt_pkg.sv =====
// Package for the band reversion trader: widths, codes and word types.
`default_nettype none
package brt_pkg;

  localparam int unsigned WINDOW   = 20;
  localparam int unsigned PRICE_W  = 24;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned K_W      = 16;
  localparam int unsigned K_FRAC   = 8;
  localparam int unsigned BAR_W    = 32;
  localparam int unsigned PROFIT_W = PRICE_W + 1;
  localparam int unsigned CNT_W    = $clog2(WINDOW + 1);
  localparam int unsigned SLOT_W   = $clog2(WINDOW);
  localparam int unsigned SUM_W    = PRICE_W + CNT_W;
  localparam int unsigned SQ_W     = 2 * PRICE_W + CNT_W;
  localparam int unsigned WQ_W     = SQ_W + CNT_W;
  localparam int unsigned MUL_W    = SUM_W;
  localparam int unsigned PROD_W   = 2 * MUL_W;
  localparam int unsigned CMP_W    = K_W + WQ_W;
  localparam int unsigned OFS_W    = PRICE_W + FRAC_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;

  localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND_K    = 2'd0,
    CFG_STOP_FRAC = 2'd1,
    CFG_TAKE_FRAC = 2'd2,
    CFG_USE_STOPS = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_LONG  = 3'd1,
    EV_SHORT = 3'd2,
    EV_STOP  = 3'd3,
    EV_TAKE  = 3'd4,
    EV_END   = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    POS_FLAT  = 2'd0,
    POS_LONG  = 2'd1,
    POS_SHORT = 2'd2
  } pos_e;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               mode;
  } in_t;

  typedef struct packed {
    logic [2:0]          event_res;
    logic [PRICE_W-1:0]  trade_price;
    logic [PRICE_W-1:0]  entry_level;
    logic [PROFIT_W-1:0] profit;
    logic [1:0]          position_after;
    logic [BAR_W-1:0]    entry_bar;
    logic [BAR_W-1:0]    exit_bar;
  } out_t;

endpackage
`default_nettype wire

// ===== hw/rtl/brt_window.sv =====
// Ring store of the last WINDOW prices, registered read.
`default_nettype none
module brt_window (
  input  wire logic                        clk_i,
  input  wire logic                        wr_en_i,
  input  wire logic                        rd_en_i,
  input  wire logic [brt_pkg::SLOT_W-1:0]  addr_i,
  input  wire logic [brt_pkg::PRICE_W-1:0] wdata_i,
  output logic      [brt_pkg::PRICE_W-1:0] rdata_o
);
  import brt_pkg::*;

  logic [PRICE_W-1:0] mem_q [WINDOW];
  logic [PRICE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/brt_mul.sv =====
// Shared unsigned multiplier with registered product.
`default_nettype none
module brt_mul (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [brt_pkg::MUL_W-1:0]  a_i,
  input  wire logic [brt_pkg::MUL_W-1:0]  b_i,
  output logic      [brt_pkg::PROD_W-1:0] prod_o
);
  import brt_pkg::*;

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// ===== hw/rtl/bollinger_reversion_trader.sv =====
// Band mean-reversion trader: sequencer around one shared multiplier.
// Paths from input accept to output valid: end of data goes straight to emit, a bar
// with no test only updates the sums, a stop check adds the stop and take offsets, and
// a band test with a full window adds the band products. The sequencer runs the products
// one at a time through the single multiplier and takes no word until it is back in idle.
// Reset (rst_ni low, async): flat, sums, fill count, slot and bar counter cleared,
// configuration registers to their defaults; the price ring itself is not cleared.
`default_nettype none
module bollinger_reversion_trader (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire brt_pkg::in_t                  in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output brt_pkg::out_t                      out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [brt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [brt_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import brt_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE    = 15'h0001,
    S_MPP     = 15'h0002,
    S_MOLD    = 15'h0004,
    S_UPDSQ   = 15'h0008,
    S_MSTOP   = 15'h0010,
    S_MTAKE   = 15'h0020,
    S_STOPCHK = 15'h0040,
    S_MD      = 15'h0080,
    S_MDD     = 15'h0100,
    S_MSS     = 15'h0200,
    S_V       = 15'h0400,
    S_MKL     = 15'h0800,
    S_MKH     = 15'h1000,
    S_CMP     = 15'h2000,
    S_EMIT    = 15'h4000
  } state_e;

  state_e state_q, state_d;

  logic [K_W-1:0]    k_q;
  logic [FRAC_W-1:0] sf_q, tf_q;
  logic              us_q;

  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SQ_W-1:0]   sq_q, sq_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  pos_e              held_pos_q, held_pos_d;
  logic [PRICE_W-1:0] held_entry_q, held_entry_d;
  logic [BAR_W-1:0]  held_bar_q, held_bar_d;
  logic [BAR_W-1:0]  bar_cnt_q;
  logic              was_full_q, was_full_d;
  logic              win_full_q, win_full_d;
  logic              out_valid_q, out_valid_d;

  logic [PRICE_W-1:0] price_q, price_d;
  logic [BAR_W-1:0]   bar_q, bar_d;
  logic [WQ_W-1:0]    wq_q, wq_d;
  logic [SUM_W-1:0]   dmag_q, dmag_d;
  logic               up_q, up_d;
  logic [PROD_W-1:0]  dd_q, dd_d;
  logic [WQ_W-1:0]    v_q, v_d;
  logic [PROD_W-1:0]  kl_q, kl_d;
  logic [PRICE_W-1:0] so_q, so_d;
  out_t               res_q, res_d;
  out_t               out_q;

  logic               accept;
  logic               win_wr;
  logic [PRICE_W-1:0] old_price;
  logic               mul_en;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  prod;

  logic [OFS_W:0]     ofs_rnd;
  logic [PRICE_W-1:0] ofs;
  logic [PRICE_W:0]   e_plus_so, e_plus_to;
  logic [PRICE_W-1:0] lvl_stop, lvl_take;
  logic               hit_stop, hit_take;
  logic [SUM_W-1:0]   wp;
  logic [CMP_W-1:0]   lhs, rhs;

  function automatic out_t mk_res(event_e ev, logic [PRICE_W-1:0] tp,
                                  logic [PRICE_W-1:0] el, logic [PROFIT_W-1:0] pr,
                                  pos_e pos, logic [BAR_W-1:0] eb,
                                  logic [BAR_W-1:0] xb);
    out_t r;
    r.event_res      = ev;
    r.trade_price    = tp;
    r.entry_level    = el;
    r.profit         = pr;
    r.position_after = pos;
    r.entry_bar      = eb;
    r.exit_bar       = xb;
    return r;
  endfunction

  function automatic logic [PROFIT_W-1:0] pnl(pos_e pos, logic [PRICE_W-1:0] lvl,
                                              logic [PRICE_W-1:0] ent);
    logic [PROFIT_W-1:0] r;
    if (pos == POS_LONG) begin
      r = {1'b0, lvl} - {1'b0, ent};
    end else begin
      r = {1'b0, ent} - {1'b0, lvl};
    end
    return r;
  endfunction

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign win_wr     = accept && !in_data_i.mode;

  brt_window u_window (
    .clk_i   (clk_i),
    .wr_en_i (win_wr),
    .rd_en_i (accept),
    .addr_i  (slot_q),
    .wdata_i (in_data_i.price),
    .rdata_o (old_price)
  );

  brt_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_MPP: begin
        mul_a = MUL_W'(price_q);
        mul_b = MUL_W'(price_q);
      end
      S_MOLD: begin
        mul_a = MUL_W'(old_price);
        mul_b = MUL_W'(old_price);
      end
      S_MSTOP: begin
        mul_a = MUL_W'(held_entry_q);
        mul_b = MUL_W'(sf_q);
      end
      S_MTAKE: begin
        mul_a = MUL_W'(held_entry_q);
        mul_b = MUL_W'(tf_q);
      end
      S_MDD: begin
        mul_a = MUL_W'(dmag_q);
        mul_b = MUL_W'(dmag_q);
      end
      S_MSS: begin
        mul_a = MUL_W'(sum_q);
        mul_b = MUL_W'(sum_q);
      end
      S_MKL: begin
        mul_a = MUL_W'(k_q);
        mul_b = v_q[MUL_W-1:0];
      end
      S_MKH: begin
        mul_a = MUL_W'(k_q);
        mul_b = MUL_W'(v_q >> MUL_W);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // rounded entry * fraction / 2^16
  assign ofs_rnd   = {1'b0, prod[OFS_W-1:0]} + (OFS_W+1)'(1 << (FRAC_W - 1));
  assign ofs       = ofs_rnd[OFS_W-1:FRAC_W];
  assign e_plus_so = {1'b0, held_entry_q} + {1'b0, so_q};
  assign e_plus_to = {1'b0, held_entry_q} + {1'b0, ofs};

  always_comb begin
    if (held_pos_q == POS_LONG) begin
      lvl_stop = held_entry_q - so_q;
      lvl_take = e_plus_to[PRICE_W] ? PRICE_MAX : e_plus_to[PRICE_W-1:0];
      hit_stop = (price_q <= lvl_stop);
      hit_take = (price_q >= lvl_take);
    end else begin
      lvl_stop = e_plus_so[PRICE_W] ? PRICE_MAX : e_plus_so[PRICE_W-1:0];
      lvl_take = held_entry_q - ofs;
      hit_stop = (price_q >= lvl_stop);
      hit_take = (price_q <= lvl_take);
    end
  end

  assign wp  = SUM_W'(WINDOW) * SUM_W'(price_q);
  assign lhs = CMP_W'({dd_q, K_FRAC'(0)});
  assign rhs = (CMP_W'(prod) << MUL_W) + CMP_W'(kl_q);

  always_comb begin
    state_d      = state_q;
    sum_d        = sum_q;
    sq_d         = sq_q;
    fill_d       = fill_q;
    slot_d       = slot_q;
    held_pos_d   = held_pos_q;
    held_entry_d = held_entry_q;
    held_bar_d   = held_bar_q;
    was_full_d   = was_full_q;
    win_full_d   = win_full_q;
    price_d      = price_q;
    bar_d        = bar_q;
    wq_d         = wq_q;
    dmag_d       = dmag_q;
    up_d         = up_q;
    dd_d         = dd_q;
    v_d          = v_q;
    kl_d         = kl_q;
    so_d         = so_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          price_d = in_data_i.price;
          bar_d   = bar_cnt_q;
          if (in_data_i.mode) begin
            if (held_pos_q != POS_FLAT) begin
              res_d = mk_res(EV_END, in_data_i.price, held_entry_q,
                             pnl(held_pos_q, in_data_i.price, held_entry_q),
                             POS_FLAT, held_bar_q, bar_cnt_q);
              held_pos_d   = POS_FLAT;
              held_entry_d = '0;
              held_bar_d   = '0;
            end else begin
              res_d = mk_res(EV_NONE, '0, '0, '0, POS_FLAT, '0, bar_cnt_q);
            end
            state_d = S_EMIT;
          end else begin
            was_full_d = (fill_q == CNT_W'(WINDOW));
            fill_d     = was_full_d ? fill_q : fill_q + 1'b1;
            win_full_d = (fill_d == CNT_W'(WINDOW));
            slot_d     = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
            state_d    = S_MPP;
          end
        end
      end
      S_MPP: begin
        state_d = S_MOLD;
      end
      S_MOLD: begin
        sum_d   = sum_q - (was_full_q ? SUM_W'(old_price) : '0) + SUM_W'(price_q);
        sq_d    = sq_q + SQ_W'(prod);
        state_d = S_UPDSQ;
      end
      S_UPDSQ: begin
        if (was_full_q) begin
          sq_d = sq_q - SQ_W'(prod);
        end
        if (held_pos_q != POS_FLAT) begin
          if (us_q) begin
            state_d = S_MSTOP;
          end else begin
            res_d   = mk_res(EV_NONE, '0, held_entry_q, '0, held_pos_q,
                             held_bar_q, bar_q);
            state_d = S_EMIT;
          end
        end else if (win_full_q) begin
          state_d = S_MD;
        end else begin
          res_d   = mk_res(EV_NONE, '0, '0, '0, POS_FLAT, '0, bar_q);
          state_d = S_EMIT;
        end
      end
      S_MSTOP: begin
        state_d = S_MTAKE;
      end
      S_MTAKE: begin
        so_d    = ofs;
        state_d = S_STOPCHK;
      end
      S_STOPCHK: begin
        if (hit_stop || hit_take) begin
          if (hit_stop) begin
            res_d = mk_res(EV_STOP, lvl_stop, held_entry_q,
                           pnl(held_pos_q, lvl_stop, held_entry_q),
                           POS_FLAT, held_bar_q, bar_q);
          end else begin
            res_d = mk_res(EV_TAKE, lvl_take, held_entry_q,
                           pnl(held_pos_q, lvl_take, held_entry_q),
                           POS_FLAT, held_bar_q, bar_q);
          end
          held_pos_d   = POS_FLAT;
          held_entry_d = '0;
          held_bar_d   = '0;
        end else begin
          res_d = mk_res(EV_NONE, '0, held_entry_q, '0, held_pos_q, held_bar_q, bar_q);
        end
        state_d = S_EMIT;
      end
      S_MD: begin
        wq_d    = WQ_W'(WINDOW) * WQ_W'(sq_q);
        up_d    = (wp > sum_q);
        dmag_d  = up_d ? wp - sum_q : sum_q - wp;
        state_d = S_MDD;
      end
      S_MDD: begin
        state_d = S_MSS;
      end
      S_MSS: begin
        dd_d    = prod;
        state_d = S_V;
      end
      S_V: begin
        v_d     = (wq_q > WQ_W'(prod)) ? wq_q - WQ_W'(prod) : '0;
        state_d = S_MKL;
      end
      S_MKL: begin
        state_d = S_MKH;
      end
      S_MKH: begin
        kl_d    = prod;
        state_d = S_CMP;
      end
      S_CMP: begin
        if ((dmag_q != '0) && (lhs > rhs)) begin
          res_d = mk_res(up_q ? EV_SHORT : EV_LONG, price_q, price_q, '0,
                         up_q ? POS_SHORT : POS_LONG, bar_q, bar_q);
          held_pos_d   = up_q ? POS_SHORT : POS_LONG;
          held_entry_d = price_q;
          held_bar_d   = bar_q;
        end else begin
          res_d = mk_res(EV_NONE, '0, '0, '0, POS_FLAT, '0, bar_q);
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sum_q        <= '0;
      sq_q         <= '0;
      fill_q       <= '0;
      slot_q       <= '0;
      held_pos_q   <= POS_FLAT;
      held_entry_q <= '0;
      held_bar_q   <= '0;
      bar_cnt_q    <= '0;
      was_full_q   <= 1'b0;
      win_full_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sum_q        <= sum_d;
      sq_q         <= sq_d;
      fill_q       <= fill_d;
      slot_q       <= slot_d;
      held_pos_q   <= held_pos_d;
      held_entry_q <= held_entry_d;
      held_bar_q   <= held_bar_d;
      was_full_q   <= was_full_d;
      win_full_q   <= win_full_d;
      out_valid_q  <= out_valid_d;
      if (accept) begin
        bar_cnt_q <= bar_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= K_W'(1024);
      sf_q <= FRAC_W'(655);
      tf_q <= FRAC_W'(655);
      us_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BAND_K:    k_q  <= cfg_wdata_i[K_W-1:0];
        CFG_STOP_FRAC: sf_q <= cfg_wdata_i[FRAC_W-1:0];
        CFG_TAKE_FRAC: tf_q <= cfg_wdata_i[FRAC_W-1:0];
        CFG_USE_STOPS: us_q <= cfg_wdata_i[0];
        default:       us_q <= us_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    price_q <= price_d;
    bar_q   <= bar_d;
    wq_q    <= wq_d;
    dmag_q  <= dmag_d;
    up_q    <= up_d;
    dd_q    <= dd_d;
    v_q     <= v_d;
    kl_q    <= kl_d;
    so_q    <= so_d;
    res_q   <= res_d;
    if ((state_q == S_EMIT) && (!out_valid_q || !out_stall_i)) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_MPP || state_q == S_EMIT))
    else $error("sequencer did not leave idle after accept");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q ##1 out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("output word loaded outside emit");

  a_flat_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_pos_q == POS_FLAT) |-> (held_entry_q == '0 && held_bar_q == '0))
    else $error("flat with stale entry");
`endif

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the band reversion trader, with its own trade predictor.
module tb;
  import brt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_WAIT  = 16;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_data;
  logic       cfg_we = 1'b0;
  cfg_idx_e   cfg_idx = CFG_BAND_K;
  logic [CFG_W-1:0] cfg_wdata = '0;

  bollinger_reversion_trader u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #6 clk_i = ~clk_i;

  // predictor state: registers, price ring, position
  logic [K_W-1:0]     k_sq = 16'd1024;
  logic [FRAC_W-1:0]  stop_fr = 16'd655;
  logic [FRAC_W-1:0]  take_fr = 16'd655;
  logic               stops_on = 1'b1;
  logic [PRICE_W-1:0] price_ring [WINDOW];
  logic [63:0]        win_sum = '0;
  logic [63:0]        win_sq = '0;
  int unsigned        fill = 0;
  int unsigned        slot = 0;
  pos_e               pos = POS_FLAT;
  logic [PRICE_W-1:0] open_price = '0;
  logic [BAR_W-1:0]   entry_no = '0;
  logic [BAR_W-1:0]   bar_no = '0;

  in_t         pending_words[$];
  out_t        expected_trades[$];
  int unsigned words_queued = 0;
  int unsigned words_accepted = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  logic        word_taken = 1'b0;
  int unsigned in_gap = 0;
  int unsigned in_calm = 0;
  int unsigned stall_left = 0;
  int unsigned out_calm = 0;
  longint      walk_px = 64'h100000;

  task automatic flatten_position(input event_e ev, input logic [63:0] level,
                                  inout out_t r);
    r.event_res      = ev;
    r.trade_price    = level[PRICE_W-1:0];
    r.entry_level    = open_price;
    r.profit         = (pos == POS_LONG) ? PROFIT_W'(level - 64'(open_price))
                                         : PROFIT_W'(64'(open_price) - level);
    r.entry_bar      = entry_no;
    r.position_after = POS_FLAT;
    pos        = POS_FLAT;
    open_price = '0;
    entry_no   = '0;
  endtask

  task automatic trade_step(input in_t w, output out_t r);
    logic [63:0] px, old, so, to, stop_lvl, take_lvl, wp, dmag, wq, s2, var_t;
    logic [95:0] lhs, rhs;
    logic [BAR_W-1:0] this_bar;
    logic up;
    px = 64'(w.price);
    this_bar = bar_no;
    bar_no = bar_no + 1;
    r = '0;
    r.exit_bar = this_bar;
    if (w.mode) begin
      if (pos != POS_FLAT) flatten_position(EV_END, px, r);
    end else begin
      if (fill >= WINDOW) begin
        old = 64'(price_ring[slot]);
        win_sum -= old;
        win_sq -= old * old;
      end else begin
        fill++;
      end
      price_ring[slot] = w.price;
      win_sum += px;
      win_sq += px * px;
      slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
      if (pos != POS_FLAT) begin
        r.entry_level    = open_price;
        r.entry_bar      = entry_no;
        r.position_after = pos;
        if (stops_on) begin
          so = (64'(open_price) * 64'(stop_fr) + 64'd32768) >> 16;
          to = (64'(open_price) * 64'(take_fr) + 64'd32768) >> 16;
          if (pos == POS_LONG) begin
            stop_lvl = 64'(open_price) - so;
            take_lvl = 64'(open_price) + to;
            if (take_lvl > 64'(PRICE_MAX)) take_lvl = 64'(PRICE_MAX);
            if (px <= stop_lvl) flatten_position(EV_STOP, stop_lvl, r);
            else if (px >= take_lvl) flatten_position(EV_TAKE, take_lvl, r);
          end else begin
            stop_lvl = 64'(open_price) + so;
            if (stop_lvl > 64'(PRICE_MAX)) stop_lvl = 64'(PRICE_MAX);
            take_lvl = 64'(open_price) - to;
            if (px >= stop_lvl) flatten_position(EV_STOP, stop_lvl, r);
            else if (px <= take_lvl) flatten_position(EV_TAKE, take_lvl, r);
          end
        end
      end else if (fill >= WINDOW) begin
        // exact band test: 256*d^2 > k^2 * (W*sumsq - sum^2)
        wp = 64'(WINDOW) * px;
        up = wp > win_sum;
        dmag = up ? wp - win_sum : win_sum - wp;
        wq = 64'(WINDOW) * win_sq;
        s2 = win_sum * win_sum;
        var_t = (wq > s2) ? wq - s2 : 64'd0;
        lhs = 96'(dmag * dmag) << 8;
        rhs = 96'(k_sq) * 96'(var_t);
        if (dmag != 0 && lhs > rhs) begin
          pos = up ? POS_SHORT : POS_LONG;
          open_price = w.price;
          entry_no = this_bar;
          r.event_res      = up ? EV_SHORT : EV_LONG;
          r.trade_price    = w.price;
          r.entry_level    = w.price;
          r.entry_bar      = this_bar;
          r.position_after = pos;
        end
      end
    end
  endtask

  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    int unsigned len;
    r = $urandom_range(0, 99);
    len = 0;
    if (calm > 0) begin
      calm--;
    end else if (r < 2) begin
      calm = $urandom_range(10, 60);
    end else if (r < 55) begin
      len = 0;
    end else if (r < 85) begin
      len = $urandom_range(1, 3);
    end else if (r < 97) begin
      len = $urandom_range(4, 10);
    end else begin
      len = $urandom_range(20, 60);
    end
    return len;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // accept input words and predict their trades
  always @(posedge clk_i) begin : accept_words
    out_t r;
    word_taken = in_valid && !in_stall;
    if (word_taken) begin
      trade_step(in_data, r);
      expected_trades.insert(expected_trades.size(), r);
      words_accepted++;
    end
  end

  // input driver
  always @(negedge clk_i) begin : drive_words
    logic next_valid;
    in_t  next_data;
    next_valid = in_valid && !word_taken;
    next_data = in_data;
    if (rst_ni && !next_valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_words.size() > 0) begin
        next_data = pending_words.pop_front();
        next_valid = 1'b1;
        in_gap = pick_gap(in_calm);
      end
    end
    in_valid <= next_valid;
    in_data <= next_data;
  end

  // output back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 5) == 0) stall_left = pick_gap(out_calm);
    end
  end

  // monitor
  always @(posedge clk_i) begin : check_trades
    out_t want;
    if (out_valid && !out_stall) begin
      if (expected_trades.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        want = expected_trades.pop_front();
        check_field("event_res", want.event_res, out_data.event_res);
        check_field("trade_price", want.trade_price, out_data.trade_price);
        check_field("entry_level", want.entry_level, out_data.entry_level);
        check_field("profit", want.profit, out_data.profit);
        check_field("position_after", want.position_after, out_data.position_after);
        check_field("entry_bar", want.entry_bar, out_data.entry_bar);
        check_field("exit_bar", want.exit_bar, out_data.exit_bar);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL bollinger_reversion_trader");
      $finish;
    end
  end

  task automatic queue_word(input logic [PRICE_W-1:0] price, input logic mode);
    in_t w;
    w.price = price;
    w.mode = mode;
    pending_words.insert(pending_words.size(), w);
    words_queued++;
  endtask

  task automatic wait_drained();
    while (words_accepted != words_queued || expected_trades.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_BAND_K:    k_sq = val;
      CFG_STOP_FRAC: stop_fr = val;
      CFG_TAKE_FRAC: take_fr = val;
      CFG_USE_STOPS: stops_on = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] k, input logic [15:0] sf,
                            input logic [15:0] tf, input logic on);
    write_cfg(CFG_BAND_K, k);
    write_cfg(CFG_STOP_FRAC, sf);
    write_cfg(CFG_TAKE_FRAC, tf);
    write_cfg(CFG_USE_STOPS, {15'd0, on});
  endtask

  // random walk with spikes, rebases, noise and end-of-data words
  task automatic queue_bars(input int unsigned count);
    int unsigned r;
    longint amp;
    longint px;
    repeat (count) begin
      r = $urandom_range(0, 99);
      amp = (walk_px >> 8) + 8;
      if (r < 4) begin
        case ($urandom_range(0, 2))
          0: walk_px = $urandom_range(0, 4095);
          1: walk_px = $urandom_range(0, PRICE_MAX);
          default: walk_px = 64'(PRICE_MAX) - $urandom_range(0, 4095);
        endcase
        px = walk_px;
      end else if (r < 7) begin
        px = $urandom_range(0, PRICE_MAX);
      end else if (r < 15) begin
        px = walk_px / 16 + amp * $urandom_range(4, 40);
        px = $urandom_range(0, 1) ? walk_px + px : walk_px - px;
      end else begin
        px = walk_px - amp + $urandom_range(0, 2 * amp);
        if (px < 0) px = 0;
        if (px > 64'(PRICE_MAX)) px = 64'(PRICE_MAX);
        walk_px = px;
      end
      if (px < 0) px = 0;
      if (px > 64'(PRICE_MAX)) px = 64'(PRICE_MAX);
      queue_word(px[PRICE_W-1:0], $urandom_range(0, 99) < 3);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: flat end of data, fill, band entries, exits, extremes
    queue_word(PRICE_MAX, 1'b1);
    for (int i = 0; i < 19; i++) queue_word(24'h100000 + (i & 1), 1'b0);
    queue_word(24'h080000, 1'b0);
    queue_word(24'h083000, 1'b0);
    queue_word(PRICE_MAX, 1'b0);
    queue_word(24'h000000, 1'b1);
    queue_word(24'h000000, 1'b0);
    queue_word(24'h000000, 1'b1);
    wait_drained();

    set_config(16'd1024, 16'd655, 16'd1311, 1'b1);
    @(posedge clk_i);
    queue_bars(200);
    wait_drained();

    set_config(16'd0, 16'd0, 16'd0, 1'b1);
    @(posedge clk_i);
    queue_bars(150);
    wait_drained();

    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    @(posedge clk_i);
    queue_bars(100);
    wait_drained();

    set_config(16'd256, 16'($urandom), 16'($urandom), 1'b0);
    @(posedge clk_i);
    queue_bars(150);
    wait_drained();

    repeat (3) begin
      set_config(16'($urandom_range(64, 4096)), 16'($urandom_range(0, 2000)),
                 16'($urandom_range(0, 2000)), 1'b1);
      @(posedge clk_i);
      queue_bars(150);
      wait_drained();
    end

    if (errors == 0) begin
      $display("PASS bollinger_reversion_trader");
    end else begin
      $display("FAIL bollinger_reversion_trader");
    end
    $finish;
  end

endmodule
